// ===== src/tpdm_pkg.sv =====
// Package for the timestamped period and duty meter.
// Holds the transfer payload types, the controller/datapath interface structs and constants.
// No dependencies.
package tpdm_pkg;

    localparam int DATA_W     = 32;
    localparam int DUTY_W     = 7;
    localparam int DUTY_SUM_W = 13;
    localparam int CYC_W      = 6;
    localparam int CAPACITY   = 64;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int PROD_W     = 39;
    localparam int STEP_W     = 6;

    localparam logic [CYC_W-1:0]  MAX_CYCLES = 6'd63;
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;

    localparam logic [STEP_W-1:0] STEPS_DUTY = 6'd7;
    localparam logic [STEP_W-1:0] STEPS_PER  = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_DAVG = 6'd13;

    localparam logic [1:0] ST_FULL     = 2'd0;
    localparam logic [1:0] ST_RECORDED = 2'd1;
    localparam logic [1:0] ST_SKIPPED  = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] sample_word;
        logic [DATA_W-1:0] capture_time;
        logic              restart;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] average_period;
        logic [DUTY_W-1:0] average_duty;
        logic [CYC_W-1:0]  full_cycles;
    } out_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] level_mask;
        logic              skip_repeats;
    } cfg_t;

    typedef struct packed {
        logic              mask_we;
        logic              skip_we;
        logic [DATA_W-1:0] wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic duty_start;
        logic duty_set;
        logic duty_take;
        logic cyc_add;
        logic avgp_start;
        logic avgp_take;
        logic avgd_start;
        logic avgd_take;
        logic avg_zero;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cyc_pend;
        logic duty_direct;
        logic count_zero;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

// ===== src/tpdm_div.sv =====
// Shared restoring divider for the meter, one quotient bit per cycle.
// Depends on tpdm_pkg.
module tpdm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tpdm_pkg::DATA_W-1:0] rem_init,
    input  logic [tpdm_pkg::DATA_W-1:0] quo_init,
    input  logic [tpdm_pkg::DATA_W-1:0] divisor,
    input  logic [tpdm_pkg::STEP_W-1:0] steps,
    output logic                       busy,
    output logic [tpdm_pkg::DATA_W-1:0] quotient
);
    import tpdm_pkg::*;

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;
    logic              ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[DATA_W-1]};
        diff     = {1'b0, trial} - {2'b00, div_reg};
        ge       = ~diff[DATA_W+1];
        rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo_next = {quo_reg[DATA_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            quo_reg <= quo_init;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/tpdm_dp.sv =====
// Datapath of the meter: configuration, record state, running sums and result register.
// Depends on tpdm_pkg and tpdm_div.
module tpdm_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpdm_pkg::cmd_t      cmd,
    output tpdm_pkg::sts_t      sts,
    input  tpdm_pkg::cfg_wr_t   cfg_wr,
    output tpdm_pkg::cfg_t      cfg,
    input  tpdm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tpdm_pkg::out_item_t m_data
);
    import tpdm_pkg::*;

    cfg_t              cfg_reg;
    in_item_t          in_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] last_word_reg;
    logic              start_level_reg;
    logic              prev_level_reg;
    logic              have_ref_reg;
    logic [DATA_W-1:0] ref_time_reg;
    logic [DATA_W-1:0] opp_time_reg;
    logic [DATA_W-1:0] period_sum_reg;
    logic [DUTY_SUM_W-1:0] duty_sum_reg;
    logic [CYC_W-1:0]  cycles_reg;
    logic              pend_reg;
    logic [DATA_W-1:0] period_reg;
    logic [DATA_W-1:0] high_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] avg_period_reg;
    logic [DUTY_W-1:0] avg_duty_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              level;
    logic              is_ref;
    logic              is_opp;
    logic              first;
    logic              is_full;
    logic              is_skip;
    logic [PROD_W-1:0] prod;
    logic              div_start;
    logic [DATA_W-1:0] div_rem;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic              div_busy;
    logic [DATA_W-1:0] div_q;

    always_comb begin
        level   = |(in_reg.sample_word & cfg_reg.level_mask);
        is_ref  = (prev_level_reg == start_level_reg) && (level != start_level_reg);
        is_opp  = (prev_level_reg != start_level_reg) && (level == start_level_reg);
        first   = (count_reg == '0);
        is_full = (count_reg >= CNT_W'(CAPACITY));
        is_skip = cfg_reg.skip_repeats && !first && (in_reg.sample_word == last_word_reg);
        prod    = PROD_W'({high_reg, 6'b0}) + PROD_W'({high_reg, 5'b0})
                + PROD_W'({high_reg, 2'b0});
    end

    always_comb begin
        div_start = cmd.duty_start | cmd.avgp_start | cmd.avgd_start;
        if (cmd.avgp_start) begin
            div_rem   = '0;
            div_quo   = period_sum_reg;
            div_dvs   = DATA_W'(cycles_reg);
            div_steps = STEPS_PER;
        end else if (cmd.avgd_start) begin
            div_rem   = '0;
            div_quo   = {duty_sum_reg, {(DATA_W-DUTY_SUM_W){1'b0}}};
            div_dvs   = DATA_W'(cycles_reg);
            div_steps = STEPS_DAVG;
        end else begin
            div_rem   = prod[PROD_W-1:DUTY_W];
            div_quo   = {prod[DUTY_W-1:0], {(DATA_W-DUTY_W){1'b0}}};
            div_dvs   = period_reg;
            div_steps = STEPS_DUTY;
        end
    end

    tpdm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .quo_init (div_quo),
        .divisor  (div_dvs),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_mask   <= DATA_W'(1);
            cfg_reg.skip_repeats <= 1'b0;
        end else begin
            if (cfg_wr.mask_we) begin
                cfg_reg.level_mask <= cfg_wr.wdata;
            end
            if (cfg_wr.skip_we) begin
                cfg_reg.skip_repeats <= cfg_wr.wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            last_word_reg   <= '0;
            start_level_reg <= 1'b0;
            prev_level_reg  <= 1'b0;
            have_ref_reg    <= 1'b0;
            ref_time_reg    <= '0;
            opp_time_reg    <= '0;
            period_sum_reg  <= '0;
            duty_sum_reg    <= '0;
            cycles_reg      <= '0;
            pend_reg        <= 1'b0;
            status_reg      <= ST_FULL;
        end else if (cmd.eval) begin
            pend_reg <= 1'b0;
            if (in_reg.restart) begin
                count_reg       <= '0;
                last_word_reg   <= '0;
                start_level_reg <= 1'b0;
                prev_level_reg  <= 1'b0;
                have_ref_reg    <= 1'b0;
                ref_time_reg    <= '0;
                opp_time_reg    <= '0;
                period_sum_reg  <= '0;
                duty_sum_reg    <= '0;
                cycles_reg      <= '0;
                status_reg      <= ST_CLEARED;
            end else if (is_full) begin
                status_reg <= ST_FULL;
            end else if (is_skip) begin
                status_reg <= ST_SKIPPED;
            end else begin
                if (first) begin
                    start_level_reg <= level;
                end else if (is_ref) begin
                    if (have_ref_reg && (cycles_reg < MAX_CYCLES)) begin
                        pend_reg <= 1'b1;
                    end
                    have_ref_reg <= 1'b1;
                    ref_time_reg <= in_reg.capture_time;
                end else if (is_opp) begin
                    opp_time_reg <= in_reg.capture_time;
                end
                prev_level_reg <= level;
                last_word_reg  <= in_reg.sample_word;
                count_reg      <= count_reg + 1'b1;
                status_reg     <= ST_RECORDED;
            end
        end else if (cmd.cyc_add) begin
            period_sum_reg <= period_sum_reg + period_reg;
            duty_sum_reg   <= duty_sum_reg + DUTY_SUM_W'(duty_reg);
            cycles_reg     <= cycles_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            period_reg <= ref_time_reg - in_reg.capture_time;
            high_reg   <= start_level_reg ? (opp_time_reg - in_reg.capture_time)
                                          : (ref_time_reg - opp_time_reg);
        end
        if (cmd.duty_set) begin
            duty_reg <= (period_reg == '0) ? '0 : DUTY_FULL;
        end else if (cmd.duty_take) begin
            duty_reg <= div_q[DUTY_W-1:0];
        end
        if (cmd.avg_zero) begin
            avg_period_reg <= '0;
            avg_duty_reg   <= '0;
        end else begin
            if (cmd.avgp_take) begin
                avg_period_reg <= div_q;
            end
            if (cmd.avgd_take) begin
                avg_duty_reg <= div_q[DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.status         <= status_reg;
            m_data_reg.average_period <= avg_period_reg;
            m_data_reg.average_duty   <= avg_duty_reg;
            m_data_reg.full_cycles    <= cycles_reg;
        end
    end

    always_comb begin
        sts.cyc_pend    = pend_reg;
        sts.duty_direct = (period_reg == '0) || (high_reg >= period_reg);
        sts.count_zero  = (cycles_reg == '0);
        sts.div_busy    = div_busy;
        sts.out_free    = !m_valid_reg || m_ready;
    end

    assign cfg     = cfg_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/tpdm_ctrl.sv =====
// Controller of the meter: sequences evaluation, duty division, sums and averages.
// Depends on tpdm_pkg.
module tpdm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output tpdm_pkg::cmd_t cmd,
    input  tpdm_pkg::sts_t sts
);
    import tpdm_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EVAL      = 4'd1;
    localparam logic [3:0] S_DUTY      = 4'd2;
    localparam logic [3:0] S_DUTY_WAIT = 4'd3;
    localparam logic [3:0] S_CYC_ADD   = 4'd4;
    localparam logic [3:0] S_AVGP      = 4'd5;
    localparam logic [3:0] S_AVGP_WAIT = 4'd6;
    localparam logic [3:0] S_AVGD      = 4'd7;
    localparam logic [3:0] S_AVGD_WAIT = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_DUTY;
            end
            S_DUTY: begin
                if (!sts.cyc_pend) begin
                    state_next = S_AVGP;
                end else if (sts.duty_direct) begin
                    cmd.duty_set = 1'b1;
                    state_next   = S_CYC_ADD;
                end else begin
                    cmd.duty_start = 1'b1;
                    state_next     = S_DUTY_WAIT;
                end
            end
            S_DUTY_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.duty_take = 1'b1;
                    state_next    = S_CYC_ADD;
                end
            end
            S_CYC_ADD: begin
                cmd.cyc_add = 1'b1;
                state_next  = S_AVGP;
            end
            S_AVGP: begin
                if (sts.count_zero) begin
                    cmd.avg_zero = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.avgp_start = 1'b1;
                    state_next     = S_AVGP_WAIT;
                end
            end
            S_AVGP_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.avgp_take = 1'b1;
                    state_next    = S_AVGD;
                end
            end
            S_AVGD: begin
                cmd.avgd_start = 1'b1;
                state_next     = S_AVGD_WAIT;
            end
            S_AVGD_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.avgd_take = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/timestamped_period_duty_meter.sv =====
// Top level of the timestamped period and duty meter: APB register decode and block wiring.
// Depends on tpdm_pkg, tpdm_ctrl and tpdm_dp.
//
//   Channel   Ports                      Direction  Carries
//   s_        s_valid, s_ready, s_data   in         sample word, capture time, restart
//   m_        m_valid, m_ready, m_data   out        status, average period and duty, cycles
//   APB       psel ... prdata            in/out     level_mask at 0x0, skip_repeats at 0x4
//
// One item is worked on at a time. An item that completes a period has its duty divided
// only when that duty needs division, and is then added to the sums; the averages of period
// and duty are divided on the shared bit-serial divider unless no period is counted yet.
// A finished result waits in the output register while the next item is taken in; an item
// that finishes before that result is taken waits in its last state until it is.
// Reset is synchronous and active low and restores the register defaults and an empty record.
module timestamped_period_duty_meter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tpdm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tpdm_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tpdm_pkg::*;

    localparam logic REG_LEVEL_MASK = 1'b0;
    localparam logic REG_SKIP       = 1'b1;

    cmd_t    cmd;
    sts_t    sts;
    cfg_t    cfg;
    cfg_wr_t cfg_wr;
    logic    wr_en;

    always_comb begin
        wr_en          = psel && penable && pwrite;
        cfg_wr.wdata   = pwdata;
        cfg_wr.mask_we = wr_en && (paddr[2] == REG_LEVEL_MASK);
        cfg_wr.skip_we = wr_en && (paddr[2] == REG_SKIP);
        unique case (paddr[2])
            REG_LEVEL_MASK: prdata = cfg.level_mask;
            REG_SKIP:       prdata = {31'b0, cfg.skip_repeats};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    tpdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tpdm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .cfg_wr  (cfg_wr),
        .cfg     (cfg),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/tpdm_checker.sv =====
// Port-level checker for the meter and the bind that attaches it to the top level.
// Depends on tpdm_pkg and timestamped_period_duty_meter.
module tpdm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input tpdm_pkg::out_item_t m_data
);
    import tpdm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result transfer changed while stalled.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_no_cycle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.full_cycles == '0) |->
            (m_data.average_period == '0) && (m_data.average_duty == '0))
        else $error("Averages non-zero without a full cycle.");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.average_duty <= DUTY_FULL))
        else $error("Average duty above one hundred.");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_CLEARED) |-> (m_data.full_cycles == '0))
        else $error("Cycles reported after a restart.");

endmodule

bind timestamped_period_duty_meter tpdm_checker u_tpdm_checker (.*);
